// ----- sv/llf_pkg.sv -----
// llf_pkg: shared constants and the elaboration-time builder for the tanh table
// used by the ladder lowpass filter core and its table module
// no dependencies
package llf_pkg;

  // configuration register indexes
  localparam logic CFG_STAGE_COEFF = 1'b0;
  localparam logic CFG_RESONANCE   = 1'b1;

  // register widths and reset values
  localparam int          COEFF_W     = 16;
  localparam int          RES_W       = 17;
  localparam logic [15:0] COEFF_RESET = 16'd6554;
  localparam logic [16:0] RES_RESET   = 17'd0;
  localparam logic [16:0] RES_ONE     = 17'h10000;

  // unity in the Q30 format of the table builder
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // restoring long division, only evaluated while building constants
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // table entry idx: tanh(8*idx/depth) in Q1.frac
  // exp(-2x) from a short series on 2x/256, squared eight times
  function automatic logic [63:0] sat_entry(input int idx, input int depth, input int frac);
    logic [63:0] y;
    logic [63:0] a;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    y  = udiv64(64'(idx) << 34, 64'(depth));
    a  = y >> 8;
    t2 = ((a * a) >> 30) >> 1;
    t3 = ((t2 * a) >> 30) / 64'd3;
    t4 = ((t3 * a) >> 30) >> 2;
    e  = ONE_Q30 + t2 + t4 - a - t3;
    for (int k = 0; k < 8; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    num = (ONE_Q30 - e) << frac;
    den = ONE_Q30 + e;
    return udiv64(num + (den >> 1), den);
  endfunction

endpackage

// ----- sv/llf_sat_lut.sv -----
// llf_sat_lut: constant tanh table with two registered read ports
// depends on llf_pkg (sat_entry)
module llf_sat_lut import llf_pkg::*; #(
  parameter int STATE_BITS      = 24,
  parameter int SAT_TABLE_DEPTH = 256,
  localparam int AW = $clog2(SAT_TABLE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic [AW-1:0]         lo_addr_i,
  input  logic [AW-1:0]         hi_addr_i,
  output logic [STATE_BITS-1:0] lo_o,
  output logic [STATE_BITS-1:0] hi_o
);

  logic [STATE_BITS-1:0] rom [SAT_TABLE_DEPTH+1];
  logic [STATE_BITS-1:0] lo_q;
  logic [STATE_BITS-1:0] hi_q;

  // table contents fixed at elaboration
  for (genvar i = 0; i <= SAT_TABLE_DEPTH; i++) begin : g_rom
    assign rom[i] = STATE_BITS'(sat_entry(i, SAT_TABLE_DEPTH, STATE_BITS - 1));
  end

  // registered reads of neighboring entries
  always_ff @(posedge clk_i) begin
    lo_q <= rom[lo_addr_i];
    hi_q <= rom[hi_addr_i];
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

// ----- sv/llf_cell.sv -----
// llf_cell: one one-pole lowpass cell of the ladder, z += round(g*(x - z))
// depends on llf_pkg (coefficient width)
module llf_cell import llf_pkg::*; #(
  parameter int STATE_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [COEFF_W-1:0]           coeff_i,
  input  logic                         en_i,
  input  logic signed [STATE_BITS:0]   x_i,
  output logic                         en_o,
  output logic signed [STATE_BITS-1:0] z_o
);

  localparam int DW = STATE_BITS + 2;
  localparam int PW = STATE_BITS + 19;

  logic signed [STATE_BITS-1:0] z_q, z_d;
  logic                         tok_q;
  logic signed [DW-1:0]         diff;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         rnd;

  // step toward the input, rounded to nearest with ties upward
  always_comb begin
    diff = DW'(x_i) - DW'(z_q);
    prod = PW'($signed({1'b0, coeff_i})) * PW'(diff);
    rnd  = prod + PW'(32768);
    z_d  = z_q + rnd[STATE_BITS+15:16];
  end

  // stage state and the token handed to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_q   <= '0;
      tok_q <= 1'b0;
    end else begin
      tok_q <= en_i;
      if (en_i) begin
        z_q <= z_d;
      end
    end
  end

  assign en_o = tok_q;
  assign z_o  = z_q;

endmodule

// ----- sv/ladder_lowpass_filter_core.sv -----
// ladder_lowpass_filter_core: four-pole ladder lowpass with resonance feedback
// and tanh saturation; depends on llf_pkg, llf_sat_lut and llf_cell
//
//   channel   signals                           direction
//   cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i  write only, no wait
//   in        in_valid_i/in_ready_o, sample_in_i    one sample per transaction
//   out       out_valid_o/out_ready_i, sample_out_o one sample per transaction
//
// samples are handled one at a time, without waiting while the output is drained:
// two products, sum and magnitude, table position, table read, interpolation,
// then each of the four ladder cells in turn; the next sample is taken as the result is stored
// a stalled output holds the finished result and the core waits in place
// reset clears the stage states and loads the register defaults
module ladder_lowpass_filter_core import llf_pkg::*; #(
  parameter int STATE_BITS      = 24,
  parameter int SAT_TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [RES_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  sample_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  sample_out_o
);

  localparam int F   = STATE_BITS - 1;
  localparam int P1W = 35;
  localparam int P2W = STATE_BITS + 18;
  localparam int VW  = STATE_BITS + 21;
  localparam int MW  = VW - 1;
  localparam int AW  = $clog2(SAT_TABLE_DEPTH + 1);
  localparam int PW  = MW + AW;
  localparam int SH  = 19 + F;
  localparam int IW  = PW - SH;
  localparam int EW  = STATE_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_POS  = 3'd2;
  localparam logic [2:0] ST_TAB  = 3'd3;
  localparam logic [2:0] ST_INT  = 3'd4;
  localparam logic [2:0] ST_CELL = 3'd5;
  localparam logic [2:0] ST_WAIT = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [COEFF_W-1:0]     coeff_q;
  logic [RES_W-1:0]       res_q;
  logic [RES_W-1:0]       res_clamp;
  logic [17:0]            drive;
  logic                   in_accept;
  logic                   fin;
  logic                   out_load;
  logic                   out_free;

  logic signed [P1W-1:0]  p1_q;
  logic signed [P2W-1:0]  p2_q;
  logic signed [VW-1:0]   v;
  logic [MW-1:0]          mag_q;
  logic                   neg_q;
  logic [PW-1:0]          pos;
  logic [IW-1:0]          idx_full;
  logic                   clamp;
  logic [AW-1:0]          lo_addr_q, hi_addr_q;
  logic [15:0]            f16_q;
  logic [EW-1:0]          tab_lo, tab_hi;
  logic [EW-1:0]          tab_diff;
  logic [EW+15:0]         interp_prod;
  logic [EW:0]            mag_out;
  logic signed [EW:0]     s_q;
  logic                   cell_go_q;

  logic                         link_en [4];
  logic signed [STATE_BITS-1:0] link_z  [4];
  logic signed [STATE_BITS:0]   link_x  [4];

  logic signed [STATE_BITS:0]   osum;
  logic signed [16:0]           ofull;
  logic signed [15:0]           sample_out_q;
  logic                         out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= COEFF_RESET;
      res_q   <= RES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STAGE_COEFF: coeff_q <= cfg_wdata_i[COEFF_W-1:0];
        CFG_RESONANCE:   res_q   <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // resonance limited to one, drive = 1 + 2*res
  assign res_clamp = (res_q > RES_ONE) ? RES_ONE : res_q;
  assign drive     = 18'(RES_ONE) + {res_clamp, 1'b0};

  // handshake and sequencing
  assign fin        = ((state_q == ST_CELL) && link_en[3]) || (state_q == ST_WAIT);
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = fin && out_free;
  assign in_ready_o = (state_q == ST_IDLE) || out_load;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ST_IDLE: if (in_accept) state_d = ST_SUM;
      ST_SUM:  state_d = ST_POS;
      ST_POS:  state_d = ST_TAB;
      ST_TAB:  state_d = ST_INT;
      ST_INT:  state_d = ST_CELL;
      ST_CELL, ST_WAIT: begin
        if (out_load) begin
          state_d = in_accept ? ST_SUM : ST_IDLE;
        end else if (fin) begin
          state_d = ST_WAIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cell_go_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cell_go_q <= (state_q == ST_INT);
    end
  end

  // saturator argument and table position
  always_comb begin
    v = (VW'(p1_q) <<< (F - 15)) - (VW'(p2_q) <<< 2);
    pos      = PW'(mag_q) * PW'(SAT_TABLE_DEPTH);
    idx_full = pos[PW-1:SH];
    clamp    = idx_full >= IW'(SAT_TABLE_DEPTH);
  end

  // interpolation between neighboring entries, sign restored
  always_comb begin
    tab_diff    = tab_hi - tab_lo;
    interp_prod = (EW + 16)'(tab_diff) * (EW + 16)'(f16_q) + (EW + 16)'(32768);
    mag_out     = (EW + 1)'(tab_lo) + (EW + 1)'(interp_prod[EW+15:16]);
  end

  // front-end pipeline registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p1_q <= P1W'(sample_in_i) * P1W'($signed({1'b0, drive}));
      p2_q <= P2W'($signed({1'b0, res_clamp})) * P2W'(link_z[3]);
    end
    if (state_q == ST_SUM) begin
      neg_q <= v[VW-1];
      mag_q <= v[VW-1] ? MW'(-v) : MW'(v);
    end
    if (state_q == ST_POS) begin
      lo_addr_q <= clamp ? AW'(SAT_TABLE_DEPTH) : idx_full[AW-1:0];
      hi_addr_q <= clamp ? AW'(SAT_TABLE_DEPTH) : idx_full[AW-1:0] + AW'(1);
      f16_q     <= clamp ? 16'd0 : pos[SH-1:SH-16];
    end
    if (state_q == ST_INT) begin
      s_q <= neg_q ? -$signed(mag_out) : $signed(mag_out);
    end
  end

  llf_sat_lut #(
    .STATE_BITS      (STATE_BITS),
    .SAT_TABLE_DEPTH (SAT_TABLE_DEPTH)
  ) u_sat_lut (
    .clk_i     (clk_i),
    .lo_addr_i (lo_addr_q),
    .hi_addr_i (hi_addr_q),
    .lo_o      (tab_lo),
    .hi_o      (tab_hi)
  );

  // ladder of four cells, one token moving down the row
  for (genvar k = 0; k < 4; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign link_x[k] = s_q;
      llf_cell #(
        .STATE_BITS (STATE_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .coeff_i (coeff_q),
        .en_i    (cell_go_q),
        .x_i     (link_x[k]),
        .en_o    (link_en[k]),
        .z_o     (link_z[k])
      );
    end else begin : g_next
      assign link_x[k] = (STATE_BITS + 1)'(link_z[k-1]);
      llf_cell #(
        .STATE_BITS (STATE_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .coeff_i (coeff_q),
        .en_i    (link_en[k-1]),
        .x_i     (link_x[k]),
        .en_o    (link_en[k]),
        .z_o     (link_z[k])
      );
    end
  end

  // last stage rounded to Q1.15 and saturated
  always_comb begin
    osum  = (STATE_BITS + 1)'(link_z[3]) + ((STATE_BITS + 1)'(1) <<< (F - 16));
    ofull = osum[STATE_BITS:F-15];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (ofull[16] != ofull[15]) begin
        sample_out_q <= ofull[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
        sample_out_q <= ofull[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

`ifndef SYNTHESIS
  // at most one cell works on the sample at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cell_go_q, link_en[0], link_en[1], link_en[2], link_en[3]}))
    else $error("more than one ladder token active");

  // an accepted transaction starts the sum step next cycle
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_SUM))
    else $error("accepted sample did not enter the sum step");

  // no cell activity while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(cell_go_q || link_en[0] || link_en[1] || link_en[2]
                               || link_en[3]))
    else $error("ladder active while idle");

  // last cell finishes only while the sequencer waits on it
  a_last_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_en[3] |-> (state_q == ST_CELL))
    else $error("last cell finished outside the cell step");
`endif

endmodule
